// File: design/cau_pkg.sv
// Shared types, constants and helper functions for the complex arithmetic unit.
// Used by every module of the unit; depends on nothing else.
`default_nettype none

package cau_pkg;

    localparam int WORD_W = 32;
    localparam int FRAC_W = 16;
    localparam int STEPS  = WORD_W;
    localparam int EXT_W  = 2 * WORD_W + 2;
    localparam int PROD_W = 2 * WORD_W;

    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUB   = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_SCALE = 4'd4,
        CMD_SDIV  = 4'd5,
        CMD_CONJ  = 4'd6,
        CMD_MAG   = 4'd7,
        CMD_MAGSQ = 4'd8,
        CMD_EQUAL = 4'd9
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DIV0 = 2'd1,
        ST_SAT  = 2'd2
    } status_t;

    // Word handed from cell to cell along the quotient and root chain.
    typedef struct packed {
        logic                is_div;
        logic                is_sqrt;
        logic                dz;
        logic                sat;
        logic                is_equal;
        logic                neg_re;
        logic                neg_im;
        logic                ovf_re;
        logic                ovf_im;
        logic [PROD_W-1:0]   den;
        logic [PROD_W-1:0]   rem_re;
        logic [PROD_W-1:0]   rem_im;
        logic [PROD_W-1:0]   pend_re;
        logic [WORD_W-1:0]   pend_im;
        logic [WORD_W-1:0]   q_re;
        logic [WORD_W-1:0]   q_im;
        logic [WORD_W-1:0]   res_re;
        logic [WORD_W-1:0]   res_im;
    } cell_t;

    typedef struct packed {
        logic              sat;
        logic [WORD_W-1:0] val;
    } sat_res_t;

    // Clamp a sign and magnitude pair to the word range.
    function automatic sat_res_t sat_fn(input logic neg, input logic [EXT_W-1:0] mag);
        logic [EXT_W-1:0] lim;
        logic [EXT_W-1:0] mag_c;
        sat_res_t         r;
        lim   = neg ? (EXT_W'(1) << (WORD_W - 1)) : ((EXT_W'(1) << (WORD_W - 1)) - EXT_W'(1));
        r.sat = mag > lim;
        mag_c = r.sat ? lim : mag;
        r.val = neg ? WORD_W'(-mag_c) : mag_c[WORD_W-1:0];
        return r;
    endfunction

    function automatic logic [EXT_W-1:0] abs_fn(input logic signed [EXT_W-1:0] v);
        return v[EXT_W-1] ? EXT_W'(-v) : EXT_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: design/cau_front.sv
// Front end of the complex arithmetic unit: magnitudes and products, signed
// combination, then result shaping and divider/root setup. Depends on cau_pkg.
`default_nettype none

module cau_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic        [3:0]            s_command,
    input  wire logic signed [31:0]           s_a_re,
    input  wire logic signed [31:0]           s_a_im,
    input  wire logic signed [31:0]           s_b_re,
    input  wire logic signed [31:0]           s_b_im,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output cau_pkg::cell_t                    m_data
);
    import cau_pkg::*;

    typedef struct packed {
        cmd_t                     cmd;
        logic                     sa_r;
        logic                     sa_i;
        logic                     sb_r;
        logic                     sb_i;
        logic [WORD_W-1:0]        mag_br;
        logic signed [WORD_W-1:0] a_re;
        logic signed [WORD_W-1:0] a_im;
        logic [PROD_W-1:0]        p0;
        logic [PROD_W-1:0]        p1;
        logic [PROD_W-1:0]        p2;
        logic [PROD_W-1:0]        p3;
        logic [PROD_W-1:0]        p4;
        logic [PROD_W-1:0]        p5;
        logic signed [WORD_W:0]   lin_re;
        logic signed [WORD_W:0]   lin_im;
        logic                     is_equal;
        logic                     dz;
    } a_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [EXT_W-1:0]  re_v;
        logic signed [EXT_W-1:0]  im_v;
        logic [PROD_W-1:0]        den;
        logic [PROD_W-1:0]        sq;
        logic signed [WORD_W:0]   lin_re;
        logic signed [WORD_W:0]   lin_im;
        logic                     is_equal;
        logic                     dz;
    } b_t;

    function automatic logic signed [EXT_W-1:0] sgn(input logic [PROD_W-1:0] p,
                                                    input logic neg);
        logic signed [EXT_W-1:0] v;
        v = $signed({2'b00, p});
        return neg ? -v : v;
    endfunction

    a_t    a_reg, a_next;
    b_t    b_reg, b_next;
    cell_t c_reg, c_next;
    logic  a_valid_reg, b_valid_reg, c_valid_reg;
    logic  a_rdy, b_rdy, c_rdy;

    assign c_rdy   = !c_valid_reg || m_ready;
    assign b_rdy   = !b_valid_reg || c_rdy;
    assign a_rdy   = !a_valid_reg || b_rdy;
    assign s_ready = a_rdy;
    assign m_valid = c_valid_reg;
    assign m_data  = c_reg;

    // Stage A: magnitudes, the six products, linear results.
    always_comb begin
        logic [WORD_W-1:0] mag_ar, mag_ai, mag_bi, op0, op1;
        logic              mag_cmd;
        a_next.cmd  = cmd_t'(s_command);
        a_next.sa_r = s_a_re[WORD_W-1];
        a_next.sa_i = s_a_im[WORD_W-1];
        a_next.sb_r = s_b_re[WORD_W-1];
        a_next.sb_i = s_b_im[WORD_W-1];
        mag_ar = a_next.sa_r ? WORD_W'(-s_a_re) : WORD_W'(s_a_re);
        mag_ai = a_next.sa_i ? WORD_W'(-s_a_im) : WORD_W'(s_a_im);
        a_next.mag_br = a_next.sb_r ? WORD_W'(-s_b_re) : WORD_W'(s_b_re);
        mag_bi = a_next.sb_i ? WORD_W'(-s_b_im) : WORD_W'(s_b_im);
        a_next.a_re = s_a_re;
        a_next.a_im = s_a_im;
        mag_cmd = (a_next.cmd == CMD_MAG) || (a_next.cmd == CMD_MAGSQ);
        op0 = mag_cmd ? mag_ar : a_next.mag_br;
        op1 = mag_cmd ? mag_ai : mag_bi;
        a_next.p0 = PROD_W'(mag_ar) * PROD_W'(op0);
        a_next.p1 = PROD_W'(mag_ai) * PROD_W'(op1);
        a_next.p2 = PROD_W'(mag_ar) * PROD_W'(mag_bi);
        a_next.p3 = PROD_W'(mag_ai) * PROD_W'(a_next.mag_br);
        a_next.p4 = PROD_W'(a_next.mag_br) * PROD_W'(a_next.mag_br);
        a_next.p5 = PROD_W'(mag_bi) * PROD_W'(mag_bi);
        a_next.lin_re = '0;
        a_next.lin_im = '0;
        case (a_next.cmd)
            CMD_ADD: begin
                a_next.lin_re = (WORD_W+1)'(s_a_re) + (WORD_W+1)'(s_b_re);
                a_next.lin_im = (WORD_W+1)'(s_a_im) + (WORD_W+1)'(s_b_im);
            end
            CMD_SUB: begin
                a_next.lin_re = (WORD_W+1)'(s_a_re) - (WORD_W+1)'(s_b_re);
                a_next.lin_im = (WORD_W+1)'(s_a_im) - (WORD_W+1)'(s_b_im);
            end
            CMD_CONJ: begin
                a_next.lin_re = (WORD_W+1)'(s_a_re);
                a_next.lin_im = -((WORD_W+1)'(s_a_im));
            end
            default: begin
                a_next.lin_re = '0;
                a_next.lin_im = '0;
            end
        endcase
        a_next.is_equal = (a_next.cmd == CMD_EQUAL) && (s_a_re == s_b_re)
                          && (s_a_im == s_b_im);
        a_next.dz = ((a_next.cmd == CMD_DIV) && (s_b_re == '0) && (s_b_im == '0))
                    || ((a_next.cmd == CMD_SDIV) && (s_b_re == '0));
    end

    // Stage B: signed sums of products, divisor, squared norm.
    always_comb begin
        logic signed [EXT_W-1:0] s0, s1, s2, s3, ax;
        s0 = sgn(a_reg.p0, a_reg.sa_r ^ a_reg.sb_r);
        s1 = sgn(a_reg.p1, a_reg.sa_i ^ a_reg.sb_i);
        s2 = sgn(a_reg.p2, a_reg.sa_r ^ a_reg.sb_i);
        s3 = sgn(a_reg.p3, a_reg.sa_i ^ a_reg.sb_r);
        ax = EXT_W'(a_reg.a_re);
        b_next.cmd      = a_reg.cmd;
        b_next.lin_re   = a_reg.lin_re;
        b_next.lin_im   = a_reg.lin_im;
        b_next.is_equal = a_reg.is_equal;
        b_next.dz       = a_reg.dz;
        b_next.sq       = a_reg.p0 + a_reg.p1;
        b_next.den      = (a_reg.cmd == CMD_SDIV) ? PROD_W'(a_reg.mag_br)
                                                  : a_reg.p4 + a_reg.p5;
        case (a_reg.cmd)
            CMD_MUL: begin
                b_next.re_v = s0 - s1;
                b_next.im_v = s2 + s3;
            end
            CMD_DIV: begin
                b_next.re_v = s0 + s1;
                b_next.im_v = s3 - s2;
            end
            CMD_SCALE: begin
                b_next.re_v = s0;
                b_next.im_v = s3;
            end
            CMD_SDIV: begin
                b_next.re_v = a_reg.sb_r ? -ax : ax;
                b_next.im_v = a_reg.sb_r ? -EXT_W'(a_reg.a_im) : EXT_W'(a_reg.a_im);
            end
            default: begin
                b_next.re_v = '0;
                b_next.im_v = '0;
            end
        endcase
    end

    // Stage C: final values for direct commands, setup for the cell chain.
    always_comb begin
        logic [EXT_W-1:0]          mag_re, mag_im;
        logic [EXT_W+FRAC_W-1:0]   n_re, n_im;
        logic [PROD_W+WORD_W-1:0]  den_sh;
        sat_res_t                  r_re, r_im;
        mag_re = abs_fn(b_reg.re_v);
        mag_im = abs_fn(b_reg.im_v);
        n_re   = {mag_re, {FRAC_W{1'b0}}};
        n_im   = {mag_im, {FRAC_W{1'b0}}};
        den_sh = {b_reg.den, {WORD_W{1'b0}}};
        c_next.is_div   = (b_reg.cmd == CMD_DIV) || (b_reg.cmd == CMD_SDIV);
        c_next.is_sqrt  = (b_reg.cmd == CMD_MAG);
        c_next.dz       = b_reg.dz;
        c_next.is_equal = b_reg.is_equal;
        c_next.neg_re   = b_reg.re_v[EXT_W-1];
        c_next.neg_im   = b_reg.im_v[EXT_W-1];
        c_next.ovf_re   = (PROD_W+WORD_W)'(n_re) >= den_sh;
        c_next.ovf_im   = (PROD_W+WORD_W)'(n_im) >= den_sh;
        c_next.den      = b_reg.den;
        c_next.rem_re   = PROD_W'(n_re >> WORD_W);
        c_next.rem_im   = PROD_W'(n_im >> WORD_W);
        c_next.pend_re  = {n_re[WORD_W-1:0], {(PROD_W-WORD_W){1'b0}}};
        c_next.pend_im  = n_im[WORD_W-1:0];
        c_next.q_re     = '0;
        c_next.q_im     = '0;
        if (b_reg.cmd == CMD_MAG) begin
            c_next.rem_re  = '0;
            c_next.pend_re = b_reg.sq;
        end
        case (b_reg.cmd)
            CMD_MUL, CMD_SCALE: begin
                r_re = sat_fn(c_next.neg_re, mag_re >> FRAC_W);
                r_im = sat_fn(c_next.neg_im, mag_im >> FRAC_W);
            end
            CMD_MAGSQ: begin
                r_re = sat_fn(1'b0, EXT_W'(b_reg.sq) >> FRAC_W);
                r_im = sat_fn(1'b0, '0);
            end
            CMD_ADD, CMD_SUB, CMD_CONJ: begin
                r_re = sat_fn(b_reg.lin_re[WORD_W], abs_fn(EXT_W'(b_reg.lin_re)));
                r_im = sat_fn(b_reg.lin_im[WORD_W], abs_fn(EXT_W'(b_reg.lin_im)));
            end
            default: begin
                r_re = sat_fn(1'b0, '0);
                r_im = sat_fn(1'b0, '0);
            end
        endcase
        c_next.sat    = r_re.sat || r_im.sat;
        c_next.res_re = r_re.val;
        c_next.res_im = r_im.val;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_rdy) begin
                a_valid_reg <= s_valid;
            end
            if (b_rdy) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_rdy) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy && s_valid) begin
            a_reg <= a_next;
        end
        if (b_rdy && a_valid_reg) begin
            b_reg <= b_next;
        end
        if (c_rdy && b_valid_reg) begin
            c_reg <= c_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cau_cell.sv
// One step of the quotient and root chain: a restoring divide step on both
// lanes, or a two-bit square root step on the real lane. Depends on cau_pkg.
`default_nettype none

module cau_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire cau_pkg::cell_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output cau_pkg::cell_t     m_data
);
    import cau_pkg::*;

    cell_t data_reg, data_next;
    logic  valid_reg;

    assign s_ready = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

    always_comb begin
        logic [EXT_W-1:0] r_re, t_re, r_im, t_im;
        logic             ge_re, ge_im;
        data_next = s_data;
        if (s_data.is_sqrt) begin
            r_re = {s_data.rem_re, s_data.pend_re[PROD_W-1 -: 2]};
            t_re = {{(EXT_W-WORD_W-2){1'b0}}, s_data.q_re, 2'b01};
            data_next.pend_re = s_data.pend_re << 2;
        end else begin
            r_re = {1'b0, s_data.rem_re, s_data.pend_re[PROD_W-1]};
            t_re = {2'b00, s_data.den};
            data_next.pend_re = s_data.pend_re << 1;
        end
        r_im  = {1'b0, s_data.rem_im, s_data.pend_im[WORD_W-1]};
        t_im  = {2'b00, s_data.den};
        ge_re = r_re >= t_re;
        ge_im = r_im >= t_im;
        data_next.rem_re  = PROD_W'(ge_re ? r_re - t_re : r_re);
        data_next.rem_im  = PROD_W'(ge_im ? r_im - t_im : r_im);
        data_next.q_re    = {s_data.q_re[WORD_W-2:0], ge_re};
        data_next.q_im    = {s_data.q_im[WORD_W-2:0], ge_im};
        data_next.pend_im = s_data.pend_im << 1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// File: design/cau_finish.sv
// Output stage: picks quotient, root or direct result, saturates, sets the
// status code and holds the word until it is taken. Depends on cau_pkg.
`default_nettype none

module cau_finish (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire cau_pkg::cell_t      s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic signed [31:0]       m_res_re,
    output logic signed [31:0]       m_res_im,
    output logic                     m_is_equal,
    output logic [1:0]               m_status
);
    import cau_pkg::*;

    logic                valid_reg;
    logic [WORD_W-1:0]   re_reg, re_next;
    logic [WORD_W-1:0]   im_reg, im_next;
    logic                eq_reg, eq_next;
    status_t             st_reg, st_next;

    assign s_ready    = !valid_reg || m_ready;
    assign m_valid    = valid_reg;
    assign m_res_re   = re_reg;
    assign m_res_im   = im_reg;
    assign m_is_equal = eq_reg;
    assign m_status   = st_reg;

    always_comb begin
        sat_res_t r_re, r_im;
        logic     sat;
        if (s_data.is_div) begin
            r_re = sat_fn(s_data.neg_re, EXT_W'({s_data.ovf_re, s_data.q_re}));
            r_im = sat_fn(s_data.neg_im, EXT_W'({s_data.ovf_im, s_data.q_im}));
            sat  = r_re.sat || r_im.sat;
        end else if (s_data.is_sqrt) begin
            r_re = sat_fn(1'b0, EXT_W'(s_data.q_re));
            r_im = sat_fn(1'b0, '0);
            sat  = r_re.sat;
        end else begin
            r_re.val = s_data.res_re;
            r_re.sat = 1'b0;
            r_im.val = s_data.res_im;
            r_im.sat = 1'b0;
            sat      = s_data.sat;
        end
        eq_next = s_data.is_equal;
        if (s_data.dz) begin
            re_next = '0;
            im_next = '0;
            st_next = ST_DIV0;
        end else begin
            re_next = r_re.val;
            im_next = r_im.val;
            st_next = sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            re_reg <= re_next;
            im_reg <= im_next;
            eq_reg <= eq_next;
            st_reg <= st_next;
        end
    end

endmodule

`default_nettype wire

// File: design/complex_arithmetic_unit_top.sv
// Top level of the complex arithmetic unit: front end, a chain of quotient and
// root cells, and the output stage. Depends on cau_pkg and all cau_ modules.
`default_nettype none

// The unit takes one word per cycle while the output side does not stall,
// each word a command and two complex operands A and B in signed Q16.16,
// and returns one result word for each, in order. Every word travels the
// same pipeline: three front stages (operand magnitudes and the six 32 by
// 32 products, their signed sums, then result shaping), one cell per
// quotient or root bit (32 cells), and the output register. Each stage
// holds its own valid flag and is ready whenever it is empty or its
// successor is ready, so a stalled output only stops the words behind it
// and empty stages still fill up. Division truncates toward zero and a zero
// divisor gives a zero result with the division-by-zero status. Any part
// outside the 32-bit range is clamped and flagged as saturated. Magnitude
// is the floor of the square root of the squared norm; the compare command
// reports in m_is_equal only.
module complex_arithmetic_unit_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [3:0]         s_command,
    input  wire logic signed [31:0] s_a_re,
    input  wire logic signed [31:0] s_a_im,
    input  wire logic signed [31:0] s_b_re,
    input  wire logic signed [31:0] s_b_im,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_res_re,
    output logic signed [31:0]      m_res_im,
    output logic                    m_is_equal,
    output logic [1:0]              m_status
);
    import cau_pkg::*;

    // Chain links: link 0 leaves the front end, link STEPS enters the output stage.
    cell_t chain_data  [0:STEPS];
    logic  chain_valid [0:STEPS];
    logic  chain_ready [0:STEPS];

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_command),
        .s_a_re    (s_a_re),
        .s_a_im    (s_a_im),
        .s_b_re    (s_b_re),
        .s_b_im    (s_b_im),
        .m_valid   (chain_valid[0]),
        .m_ready   (chain_ready[0]),
        .m_data    (chain_data[0])
    );

    // Each cell produces one quotient bit per lane, or one root bit.
    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        cau_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .s_valid (chain_valid[i]),
            .s_ready (chain_ready[i]),
            .s_data  (chain_data[i]),
            .m_valid (chain_valid[i+1]),
            .m_ready (chain_ready[i+1]),
            .m_data  (chain_data[i+1])
        );
    end

    cau_finish u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (chain_valid[STEPS]),
        .s_ready    (chain_ready[STEPS]),
        .s_data     (chain_data[STEPS]),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_res_re   (m_res_re),
        .m_res_im   (m_res_im),
        .m_is_equal (m_is_equal),
        .m_status   (m_status)
    );

endmodule

`default_nettype wire
